/* src/utxq_pkg.sv */
// shared types and constants for the uart transmit queue
package utxq_pkg;

    // payload widths
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int QCNT_W = 4;

    // operation codes on the input channel
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_RECV  = 2'd1;
    localparam logic [OP_W-1:0] OP_READY = 2'd2;

    // characters used by newline expansion
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LF,
        ST_RD
    } t_state;

endpackage

/* src/utxq_in_if.sv */
// input channel: operation and data byte with valid/ready handshake
interface utxq_in_if;
    logic                           valid;
    logic                           ready;
    logic [utxq_pkg::OP_W-1:0]      op;
    logic [utxq_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

/* src/utxq_out_if.sv */
// output channel: one result per operation with valid/ready handshake
interface utxq_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic                           tx_valid;
    logic [utxq_pkg::BYTE_W-1:0]    tx_byte;
    logic                           drain_enable;
    logic [utxq_pkg::QCNT_W-1:0]    queue_count;

    modport source (output valid, output accepted, output tx_valid, output tx_byte,
                    output drain_enable, output queue_count, input ready);
    modport sink   (input valid, input accepted, input tx_valid, input tx_byte,
                    input drain_enable, input queue_count, output ready);
endinterface

/* src/utxq_ram.sv */
// generic simple dual port ram with registered read
module utxq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/uart_tx_queue_with_priority_echo.sv */
// top level: uart transmit ring queue with a priority echo slot
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        op, data_byte
//  o_out    out  valid/ready        accepted, tx_valid, tx_byte, drain_enable, queue_count
//  cfg      in   i_cfg_we           i_cfg_wdata (newline_expand)
//
// most operations complete in ST_IDLE; a put of an expanded newline adds ST_LF (two ring
// writes through the single ram write port) and a ring pop adds ST_RD (registered
// ram read). one operation is in flight at a time.
// synchronous active-low reset clears indexes, count, flags and the priority slot;
// the ring ram itself is not cleared. a result waits in an output register, and the
// next operation is taken in the cycle that result transfers.
module uart_tx_queue_with_priority_echo #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    utxq_in_if.sink             i_in,
    utxq_out_if.source          o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW >= utxq_pkg::QCNT_W) ? AW + 1 : utxq_pkg::QCNT_W + 1;

    utxq_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_count, n_count;
    logic [utxq_pkg::BYTE_W-1:0] r_pri_byte, n_pri_byte;
    logic r_pri_wait, n_pri_wait;
    logic r_drain, n_drain;
    logic r_nl_expand;

    logic r_out_valid, n_out_valid;
    logic r_out_accepted, n_out_accepted;
    logic r_out_tx_valid, n_out_tx_valid;
    logic [utxq_pkg::BYTE_W-1:0] r_out_tx_byte, n_out_tx_byte;
    logic r_out_drain, n_out_drain;
    logic [utxq_pkg::QCNT_W-1:0] r_out_count, n_out_count;

    logic in_ready, take, expand;
    logic ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [utxq_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0] wr_idx_inc, rd_idx_inc;

    // ring store
    utxq_ram #(
        .WIDTH (utxq_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // wrapping index increments
    assign wr_idx_inc = (r_wr_idx == AW'(DEPTH - 1)) ? '0 : r_wr_idx + AW'(1);
    assign rd_idx_inc = (r_rd_idx == AW'(DEPTH - 1)) ? '0 : r_rd_idx + AW'(1);

    // take a new operation only when idle and the result register frees up
    assign in_ready = (r_state == utxq_pkg::ST_IDLE) && (!r_out_valid || o_out.ready);
    assign take     = i_in.valid && in_ready;
    assign expand   = r_nl_expand && (i_in.data_byte == utxq_pkg::BYTE_LF);

    // sequencer next state and datapath
    always_comb begin
        n_state        = r_state;
        n_wr_idx       = r_wr_idx;
        n_rd_idx       = r_rd_idx;
        n_count        = r_count;
        n_pri_byte     = r_pri_byte;
        n_pri_wait     = r_pri_wait;
        n_drain        = r_drain;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_accepted = r_out_accepted;
        n_out_tx_valid = r_out_tx_valid;
        n_out_tx_byte  = r_out_tx_byte;
        n_out_drain    = r_out_drain;
        n_out_count    = r_out_count;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = r_wr_idx;
        ram_wdata      = i_in.data_byte;

        case (r_state)
            utxq_pkg::ST_IDLE: begin
                if (take) begin
                    n_out_valid    = 1'b1;
                    n_out_accepted = 1'b0;
                    n_out_tx_valid = 1'b0;
                    n_out_tx_byte  = '0;
                    case (i_in.op)
                        utxq_pkg::OP_PUT: begin
                            if (expand) begin
                                if (r_count + CW'(2) <= CW'(DEPTH - 1)) begin
                                    // carriage return now, line feed next cycle
                                    ram_we         = 1'b1;
                                    ram_wdata      = utxq_pkg::BYTE_CR;
                                    n_wr_idx       = wr_idx_inc;
                                    n_count        = r_count + CW'(2);
                                    n_drain        = 1'b1;
                                    n_out_accepted = 1'b1;
                                    n_out_valid    = 1'b0;
                                    n_state        = utxq_pkg::ST_LF;
                                end
                            end else if (r_count + CW'(1) <= CW'(DEPTH - 1)) begin
                                ram_we         = 1'b1;
                                n_wr_idx       = wr_idx_inc;
                                n_count        = r_count + CW'(1);
                                n_drain        = 1'b1;
                                n_out_accepted = 1'b1;
                            end
                        end
                        utxq_pkg::OP_RECV: begin
                            n_pri_byte     = i_in.data_byte;
                            n_pri_wait     = 1'b1;
                            n_drain        = 1'b1;
                            n_out_accepted = 1'b1;
                        end
                        utxq_pkg::OP_READY: begin
                            if (r_pri_wait) begin
                                n_out_tx_valid = 1'b1;
                                n_out_tx_byte  = r_pri_byte;
                                n_pri_wait     = 1'b0;
                            end else if (r_count != '0) begin
                                // ring head arrives from the ram next cycle
                                ram_re         = 1'b1;
                                n_rd_idx       = rd_idx_inc;
                                n_count        = r_count - CW'(1);
                                n_out_tx_valid = 1'b1;
                                n_out_valid    = 1'b0;
                                n_state        = utxq_pkg::ST_RD;
                            end else begin
                                n_drain = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_drain = n_drain;
                    n_out_count = n_count[utxq_pkg::QCNT_W-1:0];
                end
            end
            utxq_pkg::ST_LF: begin
                ram_we      = 1'b1;
                ram_wdata   = utxq_pkg::BYTE_LF;
                n_wr_idx    = wr_idx_inc;
                n_out_valid = 1'b1;
                n_state     = utxq_pkg::ST_IDLE;
            end
            utxq_pkg::ST_RD: begin
                n_out_tx_byte = ram_rdata;
                n_out_valid   = 1'b1;
                n_state       = utxq_pkg::ST_IDLE;
            end
            default: begin
                n_state = utxq_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utxq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_count     <= '0;
            r_pri_byte  <= '0;
            r_pri_wait  <= 1'b0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_count     <= n_count;
            r_pri_byte  <= n_pri_byte;
            r_pri_wait  <= n_pri_wait;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    // newline expansion register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_expand <= 1'b1;
        end else if (i_cfg_we) begin
            r_nl_expand <= i_cfg_wdata;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_accepted <= n_out_accepted;
        r_out_tx_valid <= n_out_tx_valid;
        r_out_tx_byte  <= n_out_tx_byte;
        r_out_drain    <= n_out_drain;
        r_out_count    <= n_out_count;
    end

    // channel outputs
    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.accepted     = r_out_accepted;
    assign o_out.tx_valid     = r_out_tx_valid;
    assign o_out.tx_byte      = r_out_tx_byte;
    assign o_out.drain_enable = r_out_drain;
    assign o_out.queue_count  = r_out_count;

endmodule

/* tb/tb.sv */
// testbench for the uart transmit queue with priority echo, checked against a cycle-free predictor
`timescale 1ns / 100ps

module tb;
    import utxq_pkg::*;

    // op code the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RING_SLOTS   = 16;
    localparam int RING_BYTES   = RING_SLOTS - 1;
    localparam int ITEM_TARGET  = 1550;
    localparam int PHASES       = 6;
    localparam int TIMEOUT_NS   = 3_000_000;

    // one result of the block, field by field
    typedef struct packed {
        logic              accepted;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              drain_enable;
        logic [QCNT_W-1:0] queue_count;
    } t_tx_result;

    // predicted queue state plus the list of results still owed by the block
    class txq_scoreboard;
        logic [BYTE_W-1:0] ring_mem [RING_SLOTS];
        logic [QCNT_W-1:0] wr_ptr;
        logic [QCNT_W-1:0] rd_ptr;
        logic [BYTE_W-1:0] echo_byte;
        logic              echo_waiting;
        logic              drain_on;
        logic              crlf_on;
        t_tx_result        expected_q [$];
        int errors;
        int full_hits;
        int puts_refused;
        int echoes_sent;
        int crlf_stored;
        int empty_readies;

        function new();
            wr_ptr        = '0;
            rd_ptr        = '0;
            echo_byte     = '0;
            echo_waiting  = 1'b0;
            drain_on      = 1'b0;
            crlf_on       = 1'b1;
            errors        = 0;
            full_hits     = 0;
            puts_refused  = 0;
            echoes_sent   = 0;
            crlf_stored   = 0;
            empty_readies = 0;
        endfunction

        function void set_crlf(logic on);
            crlf_on = on;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [QCNT_W-1:0] ring_used();
            logic [QCNT_W-1:0] used;
            used = wr_ptr - rd_ptr;
            return used;
        endfunction

        function void push_byte(logic [BYTE_W-1:0] b);
            ring_mem[wr_ptr] = b;
            wr_ptr = wr_ptr + 1'b1;
        endfunction

        // work out the result of one accepted input transfer
        function void note_transfer(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
            t_tx_result r;
            int need;
            r = '0;
            case (op)
                OP_PUT: begin
                    need = (crlf_on && data == BYTE_LF) ? 2 : 1;
                    if (RING_BYTES - int'(ring_used()) >= need) begin
                        if (need == 2) begin
                            push_byte(BYTE_CR);
                            crlf_stored++;
                        end
                        push_byte(data);
                        drain_on   = 1'b1;
                        r.accepted = 1'b1;
                        if (int'(ring_used()) == RING_BYTES)
                            full_hits++;
                    end else begin
                        puts_refused++;
                    end
                end
                OP_RECV: begin
                    echo_byte    = data;
                    echo_waiting = 1'b1;
                    drain_on     = 1'b1;
                    r.accepted   = 1'b1;
                end
                OP_READY: begin
                    // echo byte goes ahead of the ring
                    if (echo_waiting) begin
                        r.tx_valid   = 1'b1;
                        r.tx_byte    = echo_byte;
                        echo_waiting = 1'b0;
                        echoes_sent++;
                    end else if (ring_used() != '0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = ring_mem[rd_ptr];
                        rd_ptr     = rd_ptr + 1'b1;
                    end else begin
                        drain_on = 1'b0;
                        empty_readies++;
                    end
                end
                default: ;
            endcase
            r.drain_enable = drain_on;
            r.queue_count  = ring_used();
            expected_q.push_back(r);
        endfunction

        task flag_error(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        // compare one result transfer with the oldest prediction
        task check_result(t_tx_result got);
            t_tx_result want;
            if (expected_q.size() == 0) begin
                flag_error($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted)
                flag_error($sformatf("accepted %b, want %b", got.accepted, want.accepted));
            if (got.tx_valid !== want.tx_valid)
                flag_error($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                flag_error($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
            if (got.drain_enable !== want.drain_enable)
                flag_error($sformatf("drain_enable %b, want %b",
                                     got.drain_enable, want.drain_enable));
            if (got.queue_count !== want.queue_count)
                flag_error($sformatf("queue_count %0d, want %0d",
                                     got.queue_count, want.queue_count));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    utxq_in_if  in_ch ();
    utxq_out_if out_ch ();

    txq_scoreboard txq_sb;
    bit gaps_on;
    int hold_cycles;
    int items_sent;
    int cfg_writes;

    uart_tx_queue_with_priority_echo dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one operation and wait for its transfer
    task automatic send_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.data_byte <= data;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        txq_sb.note_transfer(op, data);
        if (op != OP_SPARE)
            items_sent++;
    endtask

    task automatic send_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // change newline expansion once the block has drained
    task automatic write_crlf(input logic on);
        while (txq_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        txq_sb.set_crlf(on);
        cfg_writes++;
    endtask

    // line feeds come often so expansion and the two-slot check get exercised
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 3) == 0)
            return BYTE_LF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // random run biased toward filling or toward draining the ring
    task automatic run_burst(input int len, input bit filling);
        int pick;
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < (filling ? 60 : 25))
                send_op(OP_PUT, pick_byte());
            else if (pick < (filling ? 70 : 35))
                send_op(OP_RECV, BYTE_W'($urandom_range(0, 255)));
            else if (pick < 96)
                send_op(OP_READY, BYTE_W'($urandom_range(0, 255)));
            else
                send_op(OP_SPARE, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall;
        t_tx_result got;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 3) : 0;
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            got.accepted     = out_ch.accepted;
            got.tx_valid     = out_ch.tx_valid;
            got.tx_byte      = out_ch.tx_byte;
            got.drain_enable = out_ch.drain_enable;
            got.queue_count  = out_ch.queue_count;
            txq_sb.check_result(got);
        end
    end

    // stimulus
    initial begin : stimulus
        int phase;
        int n;
        bit filling;
        txq_sb          = new();
        gaps_on         = 1'b0;
        hold_cycles     = 0;
        items_sent      = 0;
        cfg_writes      = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_PUT;
        in_ch.data_byte <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: expansion on, empty ready, spare op, echo overwrite and priority
        write_crlf(1'b1);
        send_op(OP_READY, 8'hFF);
        send_op(OP_SPARE, 8'hFF);
        send_op(OP_PUT, 8'h00);
        send_op(OP_PUT, 8'hFF);
        send_op(OP_PUT, BYTE_LF);
        send_op(OP_PUT, BYTE_CR);
        send_op(OP_RECV, 8'h5A);
        send_op(OP_RECV, 8'hA5);
        repeat (7) send_op(OP_READY, 8'h00);
        send_op(OP_SPARE, 8'h00);
        send_idle();

        // directed: expansion off, line feed stored alone
        write_crlf(1'b0);
        send_op(OP_PUT, BYTE_LF);
        send_op(OP_RECV, 8'h00);
        send_op(OP_RECV, 8'hFF);
        repeat (4) send_op(OP_READY, 8'hFF);
        send_idle();

        // random phases, expansion toggled between them
        for (phase = 0; phase < PHASES; phase++) begin
            write_crlf(phase[0] ? 1'b0 : 1'b1);
            filling = 1'b1;
            while (items_sent < (ITEM_TARGET * (phase + 1)) / PHASES) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                if (phase == 1 && filling) begin
                    // receiver holds off while puts keep coming
                    hold_cycles = 60;
                    run_burst(20, 1'b1);
                end else begin
                    run_burst($urandom_range(20, 50), filling);
                end
                filling = !filling;
            end
            send_idle();
        end

        // wait for every result, then let the clock run on before the final check
        gaps_on = 1'b0;
        n = 0;
        while (txq_sb.pending() != 0 && n < 2000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        if (txq_sb.pending() != 0)
            txq_sb.flag_error($sformatf("%0d results never arrived", txq_sb.pending()));

        $display("covered %0d operations, %0d config writes, ring full %0d times",
                 items_sent, cfg_writes, txq_sb.full_hits);
        $display("refused puts %0d, echoes sent %0d, cr inserted %0d, empty readies %0d",
                 txq_sb.puts_refused, txq_sb.echoes_sent, txq_sb.crlf_stored,
                 txq_sb.empty_readies);
        if (txq_sb.errors == 0) begin
            $display("uart_tx_queue_with_priority_echo test passed");
        end else begin
            $display("uart_tx_queue_with_priority_echo test failed");
        end
        $finish;
    end

    // hard limit on run length
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("uart_tx_queue_with_priority_echo test failed");
        $finish;
    end

endmodule

/* uart_tx_queue_with_priority_echo.f */
src/utxq_pkg.sv
src/utxq_in_if.sv
src/utxq_out_if.sv
src/utxq_ram.sv
src/uart_tx_queue_with_priority_echo.sv
tb/tb.sv
